### sv/ttmf_pkg.sv
// Shared types, sizes and codes of the touch trimmed-mean filter.
// No dependencies; every other file of the block uses it by scoped name.
`timescale 1ns / 1ps

package ttmf_pkg;

   // Window geometry
   localparam int WINDOW_DEPTH = 50;
   localparam int KEEP_COUNT   = 30;

   // Field widths
   localparam int POS_W   = 12;
   localparam int SKIP_W  = 4;
   localparam int THR_W   = 18;
   localparam int LIMIT_W = 20;
   localparam int SCALE_W = 8;

   // Middle range of the sorted window that gets summed
   localparam int RANGE_LO  = (WINDOW_DEPTH / 2 >= KEEP_COUNT / 2) ?
                              WINDOW_DEPTH / 2 - KEEP_COUNT / 2 : 0;
   localparam int RANGE_HI0 = WINDOW_DEPTH / 2 + KEEP_COUNT / 2;
   localparam int RANGE_HI  = (RANGE_HI0 > WINDOW_DEPTH) ? WINDOW_DEPTH : RANGE_HI0;
   localparam int RANGE_LEN = RANGE_HI - RANGE_LO;

   // Derived widths
   localparam int WIN_IDX_W = $clog2(WINDOW_DEPTH);
   localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W     = $clog2(RANGE_LEN * ((1 << POS_W) - 1) + 1);
   localparam int MOVE_W    = SUM_W + 2;
   localparam int CMP_W     = (MOVE_W > THR_W) ? MOVE_W : THR_W;
   localparam int CNT_W     = $clog2(RANGE_LEN + 1);
   localparam int T2_W      = SCALE_W + POS_W;
   localparam int PN_W      = T2_W + POS_W;
   localparam int PM_W      = PN_W + 1;
   localparam int DEL_W     = WINDOW_DEPTH - 1;

   // Reciprocal of the range length: exact quotient for any sum of SUM_W bits
   localparam int     RECIP_SHIFT = SUM_W + $clog2(RANGE_LEN);
   localparam longint RECIP_MUL   = ((longint'(1) << RECIP_SHIFT) + RANGE_LEN - 1) / RANGE_LEN;
   localparam int     RECIP_W     = $clog2(RECIP_MUL + 1);
   localparam int     PROD_W      = SUM_W + RECIP_W;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SKIP_FAST      = 3'd0,
      CSR_SKIP_SLOW      = 3'd1,
      CSR_MOVE_THRESHOLD = 3'd2,
      CSR_PRESSURE_LIMIT = 3'd3,
      CSR_PRESSURE_SCALE = 3'd4
   } csr_index_type;

   localparam logic [SKIP_W-1:0]  SKIP_FAST_RST      = 4'd10;
   localparam logic [SKIP_W-1:0]  SKIP_SLOW_RST      = 4'd5;
   localparam logic [THR_W-1:0]   MOVE_THRESHOLD_RST = 18'd12;
   localparam logic [LIMIT_W-1:0] PRESSURE_LIMIT_RST = 20'd100000;
   localparam logic [SCALE_W-1:0] PRESSURE_SCALE_RST = 8'd21;

   typedef struct packed {
      logic [SKIP_W-1:0]  skip_fast;
      logic [SKIP_W-1:0]  skip_slow;
      logic [THR_W-1:0]   move_threshold;
      logic [LIMIT_W-1:0] pressure_limit;
      logic [SCALE_W-1:0] pressure_scale;
   } cfg_type;

   // Port payloads
   typedef struct packed {
      logic             mode;
      logic [POS_W-1:0] pressure_z1;
      logic [POS_W-1:0] pressure_z2;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
   } req_item_type;

   typedef struct packed {
      logic             report_kind;
      logic [POS_W-1:0] avg_x;
      logic [POS_W-1:0] avg_y;
   } rsp_item_type;

   localparam logic MODE_RELEASE = 1'b1;
   localparam logic KIND_IGNORE  = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   // Classified command
   typedef enum logic [1:0] {
      CMD_RELEASE = 2'd0,
      CMD_REJECT  = 2'd1,
      CMD_SAMPLE  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
   } cmd_type;

   typedef enum logic [1:0] {
      F_IDLE = 2'd0,
      F_MUL1 = 2'd1,
      F_MUL2 = 2'd2,
      F_PUSH = 2'd3
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE   = 4'd0,
      B_DECODE = 4'd1,
      B_DELETE = 4'd2,
      B_INSERT = 4'd3,
      B_LOAD   = 4'd4,
      B_SUM    = 4'd5,
      B_DIVSET = 4'd6,
      B_EMIT   = 4'd7
   } back_state_type;

endpackage

### sv/ttmf_front.sv
// Front end: takes items and classifies them (release, rejected, good sample).
// Pressure check done with two products instead of a divide. Uses ttmf_pkg.
`timescale 1ns / 1ps

module ttmf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  ttmf_pkg::req_item_type req_item,
   input  ttmf_pkg::cfg_type     cfg,
   output logic                  q_push,
   input  logic                  q_full,
   output ttmf_pkg::cmd_type     q_item
);

   ttmf_pkg::front_state_type state_ff, state_in;
   ttmf_pkg::req_item_type    item_ff;
   logic [ttmf_pkg::T2_W-1:0] t2_ff;
   logic [ttmf_pkg::PN_W-1:0] prod_n_ff;
   logic [ttmf_pkg::PM_W-1:0] prod_m_ff;
   logic                      low_ff;
   logic [ttmf_pkg::T2_W:0]   lim_sum;
   logic                      zero_read;
   logic                      bad;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ttmf_pkg::F_IDLE: if (req_push) state_in = ttmf_pkg::F_MUL1;
         ttmf_pkg::F_MUL1: state_in = ttmf_pkg::F_MUL2;
         ttmf_pkg::F_MUL2: state_in = ttmf_pkg::F_PUSH;
         ttmf_pkg::F_PUSH: if (!q_full) state_in = ttmf_pkg::F_IDLE;
         default:          state_in = ttmf_pkg::F_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_full = 1'b1;
      q_push   = 1'b0;
      case (state_ff)
         ttmf_pkg::F_IDLE: req_full = 1'b0;
         ttmf_pkg::F_PUSH: q_push = 1'b1;
         default: begin
            req_full = 1'b1;
            q_push   = 1'b0;
         end
      endcase
   end

   // p < 0  <=> scale*x > 0 and z2 < z1
   // p > limit <=> scale*x*z2 >= (scale*x + limit + 1) * z1
   assign lim_sum   = (ttmf_pkg::T2_W+1)'(t2_ff) + (ttmf_pkg::T2_W+1)'(cfg.pressure_limit)
                      + (ttmf_pkg::T2_W+1)'(1);
   assign zero_read = (item_ff.pressure_z1 == '0) || (item_ff.pressure_z2 == '0) ||
                      (item_ff.pos_x == '0) || (item_ff.pos_y == '0);
   assign bad       = zero_read || low_ff || ({1'b0, prod_n_ff} >= prod_m_ff);

   always_comb begin
      q_item.pos_x = item_ff.pos_x;
      q_item.pos_y = item_ff.pos_y;
      if (item_ff.mode == ttmf_pkg::MODE_RELEASE) q_item.kind = ttmf_pkg::CMD_RELEASE;
      else if (bad)                               q_item.kind = ttmf_pkg::CMD_REJECT;
      else                                        q_item.kind = ttmf_pkg::CMD_SAMPLE;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ttmf_pkg::F_IDLE;
      else       state_ff <= state_in;
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (state_ff == ttmf_pkg::F_IDLE && req_push) item_ff <= req_item;
      if (state_ff == ttmf_pkg::F_MUL1)
         t2_ff <= ttmf_pkg::T2_W'(cfg.pressure_scale) * ttmf_pkg::T2_W'(item_ff.pos_x);
      if (state_ff == ttmf_pkg::F_MUL2) begin
         prod_n_ff <= ttmf_pkg::PN_W'(t2_ff) * ttmf_pkg::PN_W'(item_ff.pressure_z2);
         prod_m_ff <= ttmf_pkg::PM_W'(lim_sum) * ttmf_pkg::PM_W'(item_ff.pressure_z1);
         low_ff    <= (t2_ff != '0) && (item_ff.pressure_z2 < item_ff.pressure_z1);
      end
   end

`ifndef SYNTHESIS
   a_push_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      q_push |-> req_full)
      else $error("front pushes a command while taking items");
   a_push_holds: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_full) |=> (q_push && $stable(q_item)))
      else $error("stalled command changed");
   a_take_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> (state_ff == ttmf_pkg::F_MUL1))
      else $error("accepted item not processed");
`endif

endmodule

### sv/ttmf_queue.sv
// Short command queue between front and back ends.
// Holds ttmf_pkg::cmd_type entries in registers.
`timescale 1ns / 1ps

module ttmf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ttmf_pkg::cmd_type push_item,
   input  logic              pop,
   output logic              empty,
   output ttmf_pkg::cmd_type pop_item
);

   ttmf_pkg::cmd_type                 slot_ff [ttmf_pkg::QUEUE_DEPTH];
   logic [ttmf_pkg::QIDX_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [ttmf_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   assign full     = (count_ff == ttmf_pkg::QCNT_W'(ttmf_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push)
         wr_in = (wr_ff == ttmf_pkg::QIDX_W'(ttmf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)
         rd_in = (rd_ff == ttmf_pkg::QIDX_W'(ttmf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_item;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ttmf_pkg::QCNT_W'(ttmf_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not shrink on pop");
`endif

endmodule

### sv/ttmf_back.sv
// Back end: arrival-order memory, sorted windows, trimmed sum, divide, skip logic.
// Takes commands from ttmf_queue; uses ttmf_pkg types and sizes.
`timescale 1ns / 1ps

module ttmf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ttmf_pkg::cfg_type      cfg,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  ttmf_pkg::cmd_type      q_item,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output ttmf_pkg::rsp_item_type rsp_item
);

   localparam int D = ttmf_pkg::WINDOW_DEPTH;
   localparam int L = ttmf_pkg::RANGE_LEN;

   ttmf_pkg::back_state_type state_ff, state_in;
   ttmf_pkg::cmd_type        cmd_ff;

   logic [ttmf_pkg::FILL_W-1:0]    fill_ff;
   logic [ttmf_pkg::WIN_IDX_W-1:0] ptr_ff;
   logic [ttmf_pkg::SKIP_W-1:0]    skip_ff;
   logic [ttmf_pkg::SUM_W-1:0]     last_x_ff, last_y_ff;

   logic [ttmf_pkg::POS_W-1:0] sorted_x_ff [D];
   logic [ttmf_pkg::POS_W-1:0] sorted_y_ff [D];
   logic [ttmf_pkg::POS_W-1:0] del_x [D];
   logic [ttmf_pkg::POS_W-1:0] del_y [D];
   logic [ttmf_pkg::POS_W-1:0] ins_x [D];
   logic [ttmf_pkg::POS_W-1:0] ins_y [D];
   logic [ttmf_pkg::DEL_W-1:0] eq_x_ff, eq_y_ff;
   logic [D-1:0]               le_x, le_y;
   logic [ttmf_pkg::FILL_W-1:0] ins_n;

   // Arrival-order memory: x and y side by side
   logic [2*ttmf_pkg::POS_W-1:0] order_mem [D];
   logic [2*ttmf_pkg::POS_W-1:0] order_rd_ff;

   // Trimmed-sum and divide datapath
   logic [ttmf_pkg::POS_W-1:0] win_x_ff [L];
   logic [ttmf_pkg::POS_W-1:0] win_y_ff [L];
   logic [ttmf_pkg::SUM_W-1:0] acc_x_ff, acc_y_ff;
   logic [ttmf_pkg::POS_W-1:0] quo_x_ff, quo_y_ff;
   logic [ttmf_pkg::PROD_W-1:0] prod_x, prod_y;
   logic [ttmf_pkg::CNT_W-1:0] cnt_ff;
   logic [ttmf_pkg::SUM_W-1:0] dx, dy;
   logic [ttmf_pkg::MOVE_W-1:0] move;
   logic                       report_ff;

   logic                   out_valid_ff;
   ttmf_pkg::rsp_item_type out_ff;

   logic is_full, reach, out_free;

   assign is_full  = (fill_ff == ttmf_pkg::FILL_W'(D));
   assign reach    = is_full || (fill_ff == ttmf_pkg::FILL_W'(D - 1));
   assign out_free = !out_valid_ff || rsp_pop;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ttmf_pkg::B_IDLE:
            if (!q_empty) state_in = ttmf_pkg::B_DECODE;
         ttmf_pkg::B_DECODE:
            case (cmd_ff.kind)
               ttmf_pkg::CMD_RELEASE: state_in = ttmf_pkg::B_IDLE;
               ttmf_pkg::CMD_REJECT:  state_in = ttmf_pkg::B_EMIT;
               ttmf_pkg::CMD_SAMPLE:
                  state_in = is_full ? ttmf_pkg::B_DELETE : ttmf_pkg::B_INSERT;
               default:               state_in = ttmf_pkg::B_IDLE;
            endcase
         ttmf_pkg::B_DELETE: state_in = ttmf_pkg::B_INSERT;
         ttmf_pkg::B_INSERT:
            if (!reach || skip_ff != '0) state_in = ttmf_pkg::B_IDLE;
            else                         state_in = ttmf_pkg::B_LOAD;
         ttmf_pkg::B_LOAD: state_in = ttmf_pkg::B_SUM;
         ttmf_pkg::B_SUM:
            if (cnt_ff == ttmf_pkg::CNT_W'(L - 1)) state_in = ttmf_pkg::B_DIVSET;
         ttmf_pkg::B_DIVSET: state_in = ttmf_pkg::B_EMIT;
         ttmf_pkg::B_EMIT:
            if (out_free) state_in = ttmf_pkg::B_IDLE;
         default: state_in = ttmf_pkg::B_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      q_pop = 1'b0;
      case (state_ff)
         ttmf_pkg::B_IDLE: q_pop = !q_empty;
         default:          q_pop = 1'b0;
      endcase
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   // Delete the oldest value: first match shifts the tail down, else drop the last
   always_comb begin
      for (int i = 0; i < D - 1; i++) begin
         del_x[i] = (|(eq_x_ff & ~({ttmf_pkg::DEL_W{1'b1}} << (i + 1)))) ?
                    sorted_x_ff[i+1] : sorted_x_ff[i];
         del_y[i] = (|(eq_y_ff & ~({ttmf_pkg::DEL_W{1'b1}} << (i + 1)))) ?
                    sorted_y_ff[i+1] : sorted_y_ff[i];
      end
      del_x[D-1] = sorted_x_ff[D-1];
      del_y[D-1] = sorted_y_ff[D-1];
   end

   // Insert into the first ins_n sorted entries (le marks entries that stay)
   assign ins_n = is_full ? ttmf_pkg::FILL_W'(D - 1) : fill_ff;
   always_comb begin
      for (int i = 0; i < D; i++) begin
         le_x[i] = (ttmf_pkg::FILL_W'(i) < ins_n) && !(cmd_ff.pos_x < sorted_x_ff[i]);
         le_y[i] = (ttmf_pkg::FILL_W'(i) < ins_n) && !(cmd_ff.pos_y < sorted_y_ff[i]);
      end
      ins_x[0] = le_x[0] ? sorted_x_ff[0] : cmd_ff.pos_x;
      ins_y[0] = le_y[0] ? sorted_y_ff[0] : cmd_ff.pos_y;
      for (int i = 1; i < D; i++) begin
         ins_x[i] = le_x[i] ? sorted_x_ff[i] : (le_x[i-1] ? cmd_ff.pos_x : sorted_x_ff[i-1]);
         ins_y[i] = le_y[i] ? sorted_y_ff[i] : (le_y[i-1] ? cmd_ff.pos_y : sorted_y_ff[i-1]);
      end
   end

   // Divide by the range length: multiply by the scaled reciprocal, exact for any sum
   assign prod_x = ttmf_pkg::PROD_W'(acc_x_ff) * ttmf_pkg::PROD_W'(ttmf_pkg::RECIP_MUL);
   assign prod_y = ttmf_pkg::PROD_W'(acc_y_ff) * ttmf_pkg::PROD_W'(ttmf_pkg::RECIP_MUL);

   // Movement against the last sums
   assign dx   = (last_x_ff > acc_x_ff) ? last_x_ff - acc_x_ff : acc_x_ff - last_x_ff;
   assign dy   = (last_y_ff > acc_y_ff) ? last_y_ff - acc_y_ff : acc_y_ff - last_y_ff;
   assign move = ttmf_pkg::MOVE_W'(1) + ttmf_pkg::MOVE_W'(dx) + ttmf_pkg::MOVE_W'(dy);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttmf_pkg::B_IDLE;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         skip_ff      <= '0;
         last_x_ff    <= ttmf_pkg::SUM_W'(1);
         last_y_ff    <= ttmf_pkg::SUM_W'(1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ttmf_pkg::B_EMIT && out_free) out_valid_ff <= 1'b1;
         else if (rsp_pop)                             out_valid_ff <= 1'b0;
         case (state_ff)
            ttmf_pkg::B_DECODE: begin
               if (cmd_ff.kind == ttmf_pkg::CMD_RELEASE) begin
                  fill_ff   <= '0;
                  ptr_ff    <= '0;
                  skip_ff   <= '0;
                  last_x_ff <= ttmf_pkg::SUM_W'(1);
                  last_y_ff <= ttmf_pkg::SUM_W'(1);
               end else if (cmd_ff.kind == ttmf_pkg::CMD_REJECT && !is_full) begin
                  fill_ff <= '0;
                  ptr_ff  <= '0;
               end
            end
            ttmf_pkg::B_INSERT: begin
               ptr_ff <= (ptr_ff == ttmf_pkg::WIN_IDX_W'(D - 1)) ? '0 : ptr_ff + 1'b1;
               if (!is_full) fill_ff <= fill_ff + 1'b1;
               if (reach && skip_ff != '0) skip_ff <= skip_ff - 1'b1;
            end
            ttmf_pkg::B_DIVSET: begin
               skip_ff   <= (ttmf_pkg::CMP_W'(move) > ttmf_pkg::CMP_W'(cfg.move_threshold)) ?
                            cfg.skip_fast : cfg.skip_slow;
               last_x_ff <= acc_x_ff;
               last_y_ff <= acc_y_ff;
            end
            default: ;
         endcase
      end
   end

   // Arrival-order memory, registered read at the write pointer (oldest when full)
   always_ff @(posedge clock) begin
      if (state_ff == ttmf_pkg::B_INSERT) order_mem[ptr_ff] <= {cmd_ff.pos_x, cmd_ff.pos_y};
      order_rd_ff <= order_mem[ptr_ff];
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ttmf_pkg::B_IDLE && !q_empty) cmd_ff <= q_item;

      // match flags of the oldest value, used by the delete state
      if (state_ff == ttmf_pkg::B_DECODE) begin
         for (int i = 0; i < D - 1; i++) begin
            eq_x_ff[i] <= (sorted_x_ff[i] == order_rd_ff[2*ttmf_pkg::POS_W-1:ttmf_pkg::POS_W]);
            eq_y_ff[i] <= (sorted_y_ff[i] == order_rd_ff[ttmf_pkg::POS_W-1:0]);
         end
         report_ff <= 1'b0;
      end

      if (state_ff == ttmf_pkg::B_DELETE) begin
         for (int i = 0; i < D; i++) begin
            sorted_x_ff[i] <= del_x[i];
            sorted_y_ff[i] <= del_y[i];
         end
      end

      if (state_ff == ttmf_pkg::B_INSERT) begin
         for (int i = 0; i < D; i++) begin
            sorted_x_ff[i] <= ins_x[i];
            sorted_y_ff[i] <= ins_y[i];
         end
      end

      // copy the middle range out, then accumulate one entry a cycle
      if (state_ff == ttmf_pkg::B_LOAD) begin
         for (int k = 0; k < L; k++) begin
            win_x_ff[k] <= sorted_x_ff[ttmf_pkg::RANGE_LO + k];
            win_y_ff[k] <= sorted_y_ff[ttmf_pkg::RANGE_LO + k];
         end
         acc_x_ff  <= '0;
         acc_y_ff  <= '0;
         cnt_ff    <= '0;
         report_ff <= 1'b1;
      end

      if (state_ff == ttmf_pkg::B_SUM) begin
         acc_x_ff <= acc_x_ff + ttmf_pkg::SUM_W'(win_x_ff[0]);
         acc_y_ff <= acc_y_ff + ttmf_pkg::SUM_W'(win_y_ff[0]);
         for (int k = 0; k < L - 1; k++) begin
            win_x_ff[k] <= win_x_ff[k+1];
            win_y_ff[k] <= win_y_ff[k+1];
         end
         cnt_ff <= cnt_ff + 1'b1;
      end

      // quotient is the high part of the reciprocal product
      if (state_ff == ttmf_pkg::B_DIVSET) begin
         quo_x_ff <= prod_x[ttmf_pkg::RECIP_SHIFT +: ttmf_pkg::POS_W];
         quo_y_ff <= prod_y[ttmf_pkg::RECIP_SHIFT +: ttmf_pkg::POS_W];
      end

      // result: a report or an ignore with zero coordinates
      if (state_ff == ttmf_pkg::B_EMIT && out_free) begin
         if (report_ff) begin
            out_ff.report_kind <= ttmf_pkg::KIND_REPORT;
            out_ff.avg_x       <= quo_x_ff;
            out_ff.avg_y       <= quo_y_ff;
         end else begin
            out_ff.report_kind <= ttmf_pkg::KIND_IGNORE;
            out_ff.avg_x       <= '0;
            out_ff.avg_y       <= '0;
         end
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= ttmf_pkg::FILL_W'(D))
      else $error("fill count beyond window depth");
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff < ttmf_pkg::WIN_IDX_W'(D))
      else $error("order pointer out of range");
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ttmf_pkg::B_EMIT && out_free) |=> out_valid_ff)
      else $error("result not loaded on emit");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ttmf_pkg::B_IDLE))
      else $error("command taken while busy");
`endif

endmodule

### sv/touch_trimmed_median_filter_unit.sv
// Top level of the touch trimmed-mean filter: config registers, front, queue, back.
// Depends on ttmf_pkg, ttmf_front, ttmf_queue, ttmf_back.
//
//   channel   ports                           direction  moves
//   request   req_push, req_full, req_item    in         touch sample or pen release
//   response  rsp_pop, rsp_empty, rsp_item    out        report or ignore result
//   config    csr_wr_en, csr_addr, csr_wdata  in         register write, no wait
//
// In the front a sample passes through scale*x, then two products, then the push.
// On a reported sample the back deletes from and inserts into the sorted windows,
// walks over the kept range and does a reciprocal multiply.
// Reset is synchronous; no clearing pass. A full result register stalls the back,
// a full queue stalls the front.
`timescale 1ns / 1ps

module touch_trimmed_median_filter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  ttmf_pkg::req_item_type              req_item,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output ttmf_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_wr_en,
   input  logic [ttmf_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [ttmf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   ttmf_pkg::cfg_type cfg_ff;
   logic              q_push, q_full, q_pop, q_empty;
   ttmf_pkg::cmd_type q_in_item, q_out_item;

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.skip_fast      <= ttmf_pkg::SKIP_FAST_RST;
         cfg_ff.skip_slow      <= ttmf_pkg::SKIP_SLOW_RST;
         cfg_ff.move_threshold <= ttmf_pkg::MOVE_THRESHOLD_RST;
         cfg_ff.pressure_limit <= ttmf_pkg::PRESSURE_LIMIT_RST;
         cfg_ff.pressure_scale <= ttmf_pkg::PRESSURE_SCALE_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            ttmf_pkg::CSR_SKIP_FAST:
               cfg_ff.skip_fast <= csr_wdata[ttmf_pkg::SKIP_W-1:0];
            ttmf_pkg::CSR_SKIP_SLOW:
               cfg_ff.skip_slow <= csr_wdata[ttmf_pkg::SKIP_W-1:0];
            ttmf_pkg::CSR_MOVE_THRESHOLD:
               cfg_ff.move_threshold <= csr_wdata[ttmf_pkg::THR_W-1:0];
            ttmf_pkg::CSR_PRESSURE_LIMIT:
               cfg_ff.pressure_limit <= csr_wdata[ttmf_pkg::LIMIT_W-1:0];
            ttmf_pkg::CSR_PRESSURE_SCALE:
               cfg_ff.pressure_scale <= csr_wdata[ttmf_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   ttmf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .cfg      (cfg_ff),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_item   (q_in_item)
   );

   ttmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_item (q_in_item),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (q_out_item)
   );

   ttmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_item    (q_out_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

### tb/touch_trimmed_median_filter_unit_tb.sv
// Testbench for touch_trimmed_median_filter_unit: random and directed touch items,
// a trimmed-mean predictor in a scoreboard class, and random idling on both sides.
// Depends on ttmf_pkg and the block's RTL.
`timescale 1ns / 1ps

module touch_trimmed_median_filter_unit_tb;

   localparam int EMPTY_MARK = 9999;

   // Predictor of the filter plus the store of pending results
   class filter_scoreboard;
      ttmf_pkg::cfg_type      cfg;
      int unsigned            arrival_x[ttmf_pkg::WINDOW_DEPTH];
      int unsigned            arrival_y[ttmf_pkg::WINDOW_DEPTH];
      int unsigned            ranked_x[ttmf_pkg::WINDOW_DEPTH];
      int unsigned            ranked_y[ttmf_pkg::WINDOW_DEPTH];
      int unsigned            fill, skip, prev_sum_x, prev_sum_y;
      ttmf_pkg::rsp_item_type pending[$];
      int                     errors;

      function void clear_windows();
         for (int i = 0; i < ttmf_pkg::WINDOW_DEPTH; i++) begin
            ranked_x[i] = EMPTY_MARK;
            ranked_y[i] = EMPTY_MARK;
         end
         fill = 0;
         skip = 0;
         prev_sum_x = 1;
         prev_sum_y = 1;
      endfunction

      function void reset_all();
         cfg = '{ttmf_pkg::SKIP_FAST_RST, ttmf_pkg::SKIP_SLOW_RST,
                 ttmf_pkg::MOVE_THRESHOLD_RST, ttmf_pkg::PRESSURE_LIMIT_RST,
                 ttmf_pkg::PRESSURE_SCALE_RST};
         errors = 0;
         pending.delete();
         clear_windows();
      endfunction

      // insert v among the n ascending entries
      function void rank_insert(ref int unsigned a[ttmf_pkg::WINDOW_DEPTH], input int n,
                                input int unsigned v);
         int i;
         i = 0;
         while (i < n && !(v < a[i])) i++;
         for (int j = n; j > i; j--) a[j] = a[j-1];
         a[i] = v;
      endfunction

      // drop the oldest sample from a full window and add v
      function void slide(ref int unsigned ord[ttmf_pkg::WINDOW_DEPTH],
                          ref int unsigned a[ttmf_pkg::WINDOW_DEPTH],
                          input int unsigned v);
         int i;
         i = 0;
         while (i < ttmf_pkg::WINDOW_DEPTH - 1 && a[i] != ord[0]) i++;
         for (; i < ttmf_pkg::WINDOW_DEPTH - 1; i++) a[i] = a[i+1];
         a[ttmf_pkg::WINDOW_DEPTH-1] = EMPTY_MARK;
         for (int k = 0; k < ttmf_pkg::WINDOW_DEPTH - 1; k++) ord[k] = ord[k+1];
         ord[ttmf_pkg::WINDOW_DEPTH-1] = v;
         rank_insert(a, ttmf_pkg::WINDOW_DEPTH - 1, v);
      endfunction

      function void note_item(ttmf_pkg::req_item_type it);
         longint unsigned        t1, t2;
         int unsigned            sx, sy, move, dx, dy;
         bit                     bad;
         ttmf_pkg::rsp_item_type r;
         if (it.mode == ttmf_pkg::MODE_RELEASE) begin
            clear_windows();
            return;
         end
         bad = (it.pressure_z1 == 0 || it.pressure_z2 == 0 || it.pos_x == 0 || it.pos_y == 0);
         if (!bad) begin
            t2 = longint'(cfg.pressure_scale) * it.pos_x;
            t1 = t2 * it.pressure_z2 / it.pressure_z1;
            bad = (t1 < t2) || (t1 - t2 > longint'(cfg.pressure_limit));
         end
         if (bad) begin
            if (fill < ttmf_pkg::WINDOW_DEPTH) fill = 0;
            r = '{ttmf_pkg::KIND_IGNORE, '0, '0};
            pending.push_back(r);
            return;
         end
         if (fill < ttmf_pkg::WINDOW_DEPTH) begin
            arrival_x[fill] = it.pos_x;
            arrival_y[fill] = it.pos_y;
            rank_insert(ranked_x, fill, it.pos_x);
            rank_insert(ranked_y, fill, it.pos_y);
            fill++;
            if (fill < ttmf_pkg::WINDOW_DEPTH) return;
         end else begin
            slide(arrival_x, ranked_x, it.pos_x);
            slide(arrival_y, ranked_y, it.pos_y);
         end
         if (skip > 0) begin
            skip--;
            return;
         end
         sx = 0;
         sy = 0;
         for (int i = ttmf_pkg::RANGE_LO; i < ttmf_pkg::RANGE_HI; i++) begin
            sx += ranked_x[i];
            sy += ranked_y[i];
         end
         dx = (prev_sum_x > sx) ? prev_sum_x - sx : sx - prev_sum_x;
         dy = (prev_sum_y > sy) ? prev_sum_y - sy : sy - prev_sum_y;
         move = 1 + dx + dy;
         skip = (move > cfg.move_threshold) ? cfg.skip_fast : cfg.skip_slow;
         prev_sum_x = sx;
         prev_sum_y = sy;
         r.report_kind = ttmf_pkg::KIND_REPORT;
         r.avg_x = ttmf_pkg::POS_W'(sx / ttmf_pkg::RANGE_LEN);
         r.avg_y = ttmf_pkg::POS_W'(sy / ttmf_pkg::RANGE_LEN);
         pending.push_back(r);
      endfunction

      function void check_result(ttmf_pkg::rsp_item_type got);
         ttmf_pkg::rsp_item_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result kind=%0d x=%0d y=%0d", $realtime,
                     got.report_kind, got.avg_x, got.avg_y);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.report_kind !== want.report_kind) begin
            $display("%0t: report_kind expected %0d got %0d", $realtime,
                     want.report_kind, got.report_kind);
            errors++;
         end
         if (got.avg_x !== want.avg_x) begin
            $display("%0t: avg_x expected %0d got %0d", $realtime, want.avg_x, got.avg_x);
            errors++;
         end
         if (got.avg_y !== want.avg_y) begin
            $display("%0t: avg_y expected %0d got %0d", $realtime, want.avg_y, got.avg_y);
            errors++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_push, req_full, rsp_empty, rsp_pop, csr_wr_en;
   ttmf_pkg::req_item_type          req_item;
   ttmf_pkg::rsp_item_type          rsp_item;
   logic [ttmf_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [ttmf_pkg::CSR_DATA_W-1:0] csr_wdata;

   filter_scoreboard sb;
   int               send_idle, recv_stall, hold_left;

   touch_trimmed_median_filter_unit dut (.*);

   always #10 clock = ~clock;

   // Result side: check accepted items, then pick pop for the next edge
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) sb.check_result(rsp_item);
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= recv_stall);
         end
      end
   end

   task automatic send(ttmf_pkg::req_item_type it);
      while ($urandom_range(0, 99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      sb.note_item(it);
   endtask

   task automatic write_reg(ttmf_pkg::csr_index_type idx, int unsigned v);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= ttmf_pkg::CSR_DATA_W'(v);
      @(posedge clock);
   endtask

   // Wait for the block to drain, then rewrite all registers
   task automatic reconfigure(int unsigned sf, int unsigned ss, int unsigned thr,
                              int unsigned lim, int unsigned sc);
      req_push <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      write_reg(ttmf_pkg::CSR_SKIP_FAST, sf);
      write_reg(ttmf_pkg::CSR_SKIP_SLOW, ss);
      write_reg(ttmf_pkg::CSR_MOVE_THRESHOLD, thr);
      write_reg(ttmf_pkg::CSR_PRESSURE_LIMIT, lim);
      write_reg(ttmf_pkg::CSR_PRESSURE_SCALE, sc);
      csr_wr_en <= 1'b0;
      sb.cfg = '{ttmf_pkg::SKIP_W'(sf), ttmf_pkg::SKIP_W'(ss), ttmf_pkg::THR_W'(thr),
                 ttmf_pkg::LIMIT_W'(lim), ttmf_pkg::SCALE_W'(sc)};
   endtask

   function automatic ttmf_pkg::req_item_type touch(int unsigned z1, z2, x, y);
      ttmf_pkg::req_item_type it;
      it = '{1'b0, ttmf_pkg::POS_W'(z1), ttmf_pkg::POS_W'(z2), ttmf_pkg::POS_W'(x),
             ttmf_pkg::POS_W'(y)};
      return it;
   endfunction

   // Sample with low pressure: z2 at or a little above z1
   function automatic ttmf_pkg::req_item_type good_touch();
      int unsigned z1, z2;
      z1 = $urandom_range(1, 4095);
      z2 = ($urandom_range(0, 3) == 0) ? z1 : z1 + $urandom_range(0, z1 / 32);
      if (z2 > 4095) z2 = 4095;
      return touch(z1, z2, $urandom_range(1, 4095), $urandom_range(1, 4095));
   endfunction

   function automatic ttmf_pkg::req_item_type noise_touch();
      ttmf_pkg::req_item_type it;
      it = touch($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095));
      case ($urandom_range(0, 3))
         0: it.mode = ttmf_pkg::MODE_RELEASE;
         1: case ($urandom_range(0, 3))
               0: it.pressure_z1 = '0;
               1: it.pressure_z2 = '0;
               2: it.pos_x = '0;
               default: it.pos_y = '0;
            endcase
         default: ;
      endcase
      return it;
   endfunction

   // Mostly long runs of clean samples so the window fills and reports flow
   task automatic random_items(int count);
      int n;
      n = 0;
      while (n < count) begin
         repeat ($urandom_range(60, 160)) begin
            if (n < count) begin
               send(good_touch());
               n++;
            end
         end
         repeat ($urandom_range(0, 3)) begin
            if (n < count) begin
               send(noise_touch());
               n++;
            end
         end
      end
   endtask

   initial begin
      ttmf_pkg::req_item_type rel;
      sb = new();
      sb.reset_all();
      send_idle  = 0;
      recv_stall = 0;
      hold_left  = 0;
      reset      = 1'b1;
      req_push   = 1'b0;
      req_item   = '0;
      csr_wr_en  = 1'b0;
      csr_addr   = ttmf_pkg::CSR_SKIP_FAST;
      csr_wdata  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: release, zero readings, extremes, negative and huge pressure
      rel = '0;
      rel.mode = ttmf_pkg::MODE_RELEASE;
      send(rel);
      send(touch(0, 0, 0, 0));
      send(touch(0, 100, 100, 100));
      send(touch(100, 0, 100, 100));
      send(touch(100, 100, 0, 100));
      send(touch(100, 100, 100, 0));
      send(touch(4095, 4095, 4095, 4095));
      send(touch(1, 1, 1, 1));
      send(touch(2000, 1000, 500, 500));
      send(touch(1, 4095, 4095, 4095));
      send(touch(4095, 4095, 4095, 4095));
      send(rel);
      send(touch(4095, 4095, 1, 4095));
      random_items(240);

      // extremes: no skipping, every move fast, largest pressure limit and scale
      reconfigure(0, 0, 0, 20'hFFFFF, 255);
      send_idle = 72;
      random_items(250);

      // other extremes: long skips, never fast, zero limit, zero scale
      reconfigure(15, 15, 18'h3FFFF, 0, 0);
      send_idle  = 0;
      recv_stall = 72;
      random_items(250);

      reconfigure($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 2000),
                  $urandom_range(20000, 1048575), $urandom_range(0, 255));
      send_idle  = 30;
      recv_stall = 30;
      random_items(250);

      // back-pressure: receiver holds off while the sender keeps pushing
      reconfigure(0, 1, 12, 100000, 21);
      send_idle  = 0;
      recv_stall = 0;
      hold_left  = 3000;
      random_items(300);

      req_push <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Run limit
   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
sv/ttmf_pkg.sv
sv/ttmf_front.sv
sv/ttmf_queue.sv
sv/ttmf_back.sv
sv/touch_trimmed_median_filter_unit.sv
tb/touch_trimmed_median_filter_unit_tb.sv
